@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// concurrent checks on a clock with an active-low reset
`define ASSERT_IMP(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`endif

@@ hw/rtl/stbpq_pkg.sv @@
`timescale 1ns / 1ps
package stbpq_pkg;
    localparam int PRI_W   = 6;
    localparam int LOC_W   = 32;
    localparam int ENTRY_W = PRI_W + LOC_W;
    localparam int TOTAL_W = 12;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FAULT = 2'd3;

    localparam logic [1:0] ROLE_TOP = 2'd0;
    localparam logic [1:0] ROLE_MID = 2'd1;
    localparam logic [1:0] ROLE_BOT = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EVAL  = 5'b00010,
        S_COPY  = 5'b00100,
        S_MERGE = 5'b01000,
        S_POP   = 5'b10000
    } t_state;
endpackage

@@ hw/rtl/stbpq_ram.sv @@
`timescale 1ns / 1ps
module stbpq_ram #(
    parameter int AW = 12,
    parameter int DW = 38
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

@@ hw/rtl/sliding_three_bucket_priority_queue.sv @@
`timescale 1ns / 1ps
// push without a slide goes through EVAL, a pop through POP, then the result register; one word at a time
// a merging slide runs COPY per copied word, then MERGE and back to EVAL, bounded by the single memory port pair
// any word while the sticky fault (status 3) is set, or a pop on an empty queue, answers in the next cycle
// results cannot be stalled: o_valid is high for exactly one cycle per accepted word
// synchronous active-low reset clears counts, heads, roles, maximum and fault; memory is not cleared
module sliding_three_bucket_priority_queue #(
    parameter int RING_DEPTH_LOG2 = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [5:0]  i_item_pri,
    input  logic [31:0] i_item_loc,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [5:0]  o_out_pri,
    output logic [31:0] o_out_loc,
    output logic [11:0] o_total_count,
    output logic        o_queue_empty,
    output logic [5:0]  o_window_max
);
    localparam int L  = RING_DEPTH_LOG2;
    localparam int AW = L + 2;
    localparam int TW = L + 3;
    localparam int EW = stbpq_pkg::ENTRY_W;
    localparam logic [L:0] FULL = {1'b1, {L{1'b0}}};

    stbpq_pkg::t_state r_state, n_state;
    logic [L-1:0] r_head  [3];
    logic [L-1:0] n_head  [3];
    logic [L:0]   r_count [3];
    logic [L:0]   n_count [3];
    logic [1:0]   r_role  [3];
    logic [1:0]   n_role  [3];
    logic [5:0]   r_max, n_max;
    logic         r_seen, n_seen;
    logic         r_fault, n_fault;
    logic [5:0]   r_pri, n_pri;
    logic [31:0]  r_loc, n_loc;
    logic         r_case, n_case;
    logic [L:0]   r_len, n_len;
    logic [L:0]   r_idx, n_idx;
    logic [1:0]   r_src_ring, n_src_ring;
    logic [L-1:0] r_src_pos, n_src_pos;
    logic [1:0]   r_dst_ring, n_dst_ring;
    logic [L-1:0] r_dst_pos, n_dst_pos;
    logic [L:0]   r_sum, n_sum;
    logic         r_cp_v, n_cp_v;
    logic [AW-1:0] r_cp_addr, n_cp_addr;
    logic         r_valid, n_valid;
    logic [1:0]   r_status, n_status;
    logic [5:0]   r_opri, n_opri;
    logic [31:0]  r_oloc, n_oloc;

    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;

    logic [1:0]   rt, rm, rb, pr;
    logic [L:0]   cnt_t, cnt_m, cnt_b;
    logic [L+1:0] msum;
    logic [6:0]   pri_x, max_x;
    logic [TW-1:0] total;

    stbpq_ram #(.AW(AW), .DW(EW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        n_head = r_head;
        n_count = r_count;
        n_role = r_role;
        n_max = r_max;
        n_seen = r_seen;
        n_fault = r_fault;
        n_pri = r_pri;
        n_loc = r_loc;
        n_case = r_case;
        n_len = r_len;
        n_idx = r_idx;
        n_src_ring = r_src_ring;
        n_src_pos = r_src_pos;
        n_dst_ring = r_dst_ring;
        n_dst_pos = r_dst_pos;
        n_sum = r_sum;
        n_cp_v = 1'b0;
        n_cp_addr = r_cp_addr;
        n_valid = 1'b0;
        n_status = r_status;
        n_opri = r_opri;
        n_oloc = r_oloc;
        re = 1'b0;
        raddr = '0;
        we = r_cp_v;
        waddr = r_cp_addr;
        wdata = rdata;
        rt = r_role[stbpq_pkg::ROLE_TOP];
        rm = r_role[stbpq_pkg::ROLE_MID];
        rb = r_role[stbpq_pkg::ROLE_BOT];
        cnt_t = r_count[rt];
        cnt_m = r_count[rm];
        cnt_b = r_count[rb];
        msum = {1'b0, cnt_b} + {1'b0, cnt_m};
        pri_x = {1'b0, r_pri};
        max_x = {1'b0, r_max};
        pr = rt;
        case (r_state)
            stbpq_pkg::S_IDLE: begin
                if (start) begin
                    if (r_fault) begin
                        n_valid = 1'b1;
                        n_status = stbpq_pkg::ST_FAULT;
                        n_opri = '0;
                        n_oloc = '0;
                    end else if (i_func == stbpq_pkg::FUNC_POP) begin
                        if (cnt_b != '0) begin
                            re = 1'b1;
                            raddr = {rb, r_head[rb]};
                            n_head[rb] = r_head[rb] + L'(1);
                            n_count[rb] = cnt_b - (L+1)'(1);
                            n_state = stbpq_pkg::S_POP;
                        end else if (cnt_m != '0) begin
                            re = 1'b1;
                            raddr = {rm, r_head[rm] + cnt_m[L-1:0] - L'(1)};
                            n_count[rm] = cnt_m - (L+1)'(1);
                            n_state = stbpq_pkg::S_POP;
                        end else if (cnt_t != '0) begin
                            re = 1'b1;
                            raddr = {rt, r_head[rt]};
                            n_head[rt] = r_head[rt] + L'(1);
                            n_count[rt] = cnt_t - (L+1)'(1);
                            n_state = stbpq_pkg::S_POP;
                        end else begin
                            n_valid = 1'b1;
                            n_status = stbpq_pkg::ST_EMPTY;
                            n_opri = '0;
                            n_oloc = '0;
                        end
                    end else begin
                        n_pri = i_item_pri;
                        n_loc = i_item_loc;
                        n_state = stbpq_pkg::S_EVAL;
                    end
                end
            end
            stbpq_pkg::S_EVAL: begin
                if (r_seen && pri_x + 7'd2 > max_x && pri_x + 7'd1 != max_x
                        && r_max < r_pri) begin
                    if (cnt_b <= cnt_m) begin
                        if (cnt_b == '0) begin
                            n_role[stbpq_pkg::ROLE_TOP] = rb;
                            n_role[stbpq_pkg::ROLE_MID] = rt;
                            n_role[stbpq_pkg::ROLE_BOT] = rm;
                            n_max = r_max + 6'd1;
                        end else if (msum > {1'b0, FULL}) begin
                            n_fault = 1'b1;
                        end else begin
                            n_case = 1'b0;
                            n_len = cnt_b;
                            n_idx = '0;
                            n_src_ring = rb;
                            n_src_pos = r_head[rb];
                            n_dst_ring = rm;
                            n_dst_pos = r_head[rm] - cnt_b[L-1:0];
                            n_sum = msum[L:0];
                            n_state = stbpq_pkg::S_COPY;
                        end
                    end else begin
                        if (cnt_m == '0) begin
                            n_role[stbpq_pkg::ROLE_TOP] = rm;
                            n_role[stbpq_pkg::ROLE_MID] = rt;
                            n_role[stbpq_pkg::ROLE_BOT] = rb;
                            n_max = r_max + 6'd1;
                        end else if (msum > {1'b0, FULL}) begin
                            n_fault = 1'b1;
                        end else begin
                            n_case = 1'b1;
                            n_len = cnt_m;
                            n_idx = '0;
                            n_src_ring = rm;
                            n_src_pos = r_head[rm];
                            n_dst_ring = rb;
                            n_dst_pos = r_head[rb] + cnt_b[L-1:0];
                            n_sum = msum[L:0];
                            n_state = stbpq_pkg::S_COPY;
                        end
                    end
                    if (n_fault) begin
                        n_valid = 1'b1;
                        n_status = stbpq_pkg::ST_FAULT;
                        n_opri = '0;
                        n_oloc = '0;
                        n_state = stbpq_pkg::S_IDLE;
                    end
                end else begin
                    if (!r_seen) begin
                        n_max = r_pri;
                        n_seen = 1'b1;
                        pr = rt;
                    end else if (pri_x + 7'd2 <= max_x) begin
                        pr = rb;
                    end else if (pri_x + 7'd1 == max_x) begin
                        pr = rm;
                    end else begin
                        pr = rt;
                    end
                    n_valid = 1'b1;
                    n_opri = '0;
                    n_oloc = '0;
                    n_state = stbpq_pkg::S_IDLE;
                    if (r_count[pr] == FULL) begin
                        n_status = stbpq_pkg::ST_FULL;
                    end else begin
                        n_status = stbpq_pkg::ST_OK;
                        we = 1'b1;
                        waddr = {pr, r_head[pr] + r_count[pr][L-1:0]};
                        wdata = {r_pri, r_loc};
                        n_count[pr] = r_count[pr] + (L+1)'(1);
                    end
                end
            end
            stbpq_pkg::S_COPY: begin
                re = 1'b1;
                raddr = {r_src_ring, r_src_pos + r_idx[L-1:0]};
                n_cp_v = 1'b1;
                n_cp_addr = {r_dst_ring, r_dst_pos + r_idx[L-1:0]};
                n_idx = r_idx + (L+1)'(1);
                if (r_idx == r_len - (L+1)'(1)) begin
                    n_state = stbpq_pkg::S_MERGE;
                end
            end
            stbpq_pkg::S_MERGE: begin
                if (!r_case) begin
                    n_head[rm] = r_dst_pos;
                    n_count[rm] = r_sum;
                    n_head[rb] = '0;
                    n_count[rb] = '0;
                    n_role[stbpq_pkg::ROLE_TOP] = rb;
                    n_role[stbpq_pkg::ROLE_MID] = rt;
                    n_role[stbpq_pkg::ROLE_BOT] = rm;
                end else begin
                    n_count[rb] = r_sum;
                    n_head[rm] = '0;
                    n_count[rm] = '0;
                    n_role[stbpq_pkg::ROLE_TOP] = rm;
                    n_role[stbpq_pkg::ROLE_MID] = rt;
                    n_role[stbpq_pkg::ROLE_BOT] = rb;
                end
                n_max = r_max + 6'd1;
                n_state = stbpq_pkg::S_EVAL;
            end
            stbpq_pkg::S_POP: begin
                n_valid = 1'b1;
                n_status = stbpq_pkg::ST_OK;
                n_opri = rdata[EW-1:stbpq_pkg::LOC_W];
                n_oloc = rdata[stbpq_pkg::LOC_W-1:0];
                n_state = stbpq_pkg::S_IDLE;
            end
            default: begin
                n_state = stbpq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stbpq_pkg::S_IDLE;
            r_head <= '{default: '0};
            r_count <= '{default: '0};
            r_role <= '{stbpq_pkg::ROLE_TOP, stbpq_pkg::ROLE_MID, stbpq_pkg::ROLE_BOT};
            r_max <= '0;
            r_seen <= 1'b0;
            r_fault <= 1'b0;
            r_cp_v <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head <= n_head;
            r_count <= n_count;
            r_role <= n_role;
            r_max <= n_max;
            r_seen <= n_seen;
            r_fault <= n_fault;
            r_cp_v <= n_cp_v;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pri <= n_pri;
        r_loc <= n_loc;
        r_case <= n_case;
        r_len <= n_len;
        r_idx <= n_idx;
        r_src_ring <= n_src_ring;
        r_src_pos <= n_src_pos;
        r_dst_ring <= n_dst_ring;
        r_dst_pos <= n_dst_pos;
        r_sum <= n_sum;
        r_cp_addr <= n_cp_addr;
        r_status <= n_status;
        r_opri <= n_opri;
        r_oloc <= n_oloc;
    end

    assign total = TW'(r_count[0]) + TW'(r_count[1]) + TW'(r_count[2]);
    assign busy = (r_state != stbpq_pkg::S_IDLE);
    assign o_valid = r_valid;
    assign o_status = r_status;
    assign o_out_pri = r_opri;
    assign o_out_loc = r_oloc;
    assign o_total_count = 12'(total);
    assign o_queue_empty = (total == '0);
    assign o_window_max = r_max;
endmodule

@@ hw/rtl/stbpq_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stbpq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [1:0]  o_status,
    input logic [5:0]  o_out_pri,
    input logic [31:0] o_out_loc,
    input logic [11:0] o_total_count,
    input logic        o_queue_empty
);
    // every result word follows an accepted word or a busy cycle
    `ASSERT_IMP(a_valid_cause, i_clk, i_rst_n, o_valid, $past(busy || start))
    // only words with status ok may carry a payload
    `ASSERT_IMP(a_zero_payload, i_clk, i_rst_n, o_valid && o_status != stbpq_pkg::ST_OK, o_out_pri == 6'd0 && o_out_loc == 32'd0)
    // after a fault answer the total count stays stable
    `ASSERT_NXT(a_fault_frozen, i_clk, i_rst_n, o_valid && o_status == stbpq_pkg::ST_FAULT, $stable(o_total_count))
    // empty pop only on an empty queue
    `ASSERT_IMP(a_empty_pop, i_clk, i_rst_n, o_valid && o_status == stbpq_pkg::ST_EMPTY, o_queue_empty)
endmodule

bind sliding_three_bucket_priority_queue stbpq_checker u_stbpq_checker (.*);

@@ sim/tb_sliding_three_bucket_priority_queue.sv @@
`timescale 1ns / 1ps
module tb_sliding_three_bucket_priority_queue;

    localparam int DEPTH_LOG2 = 10;
    localparam int DEPTH      = 1 << DEPTH_LOG2;
    localparam int MASK       = DEPTH - 1;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [1:0]  status;
        logic [5:0]  pri;
        logic [31:0] loc;
        logic [11:0] total;
        logic        empty;
        logic [5:0]  wmax;
    } t_word_res;

    typedef struct {
        logic        func;
        logic [5:0]  pri;
        logic [31:0] loc;
        bit          typed;
        t_word_res   res;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_func = stbpq_pkg::FUNC_PUSH;
    logic [5:0]  i_item_pri = '0;
    logic [31:0] i_item_loc = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [5:0]  o_out_pri;
    logic [31:0] o_out_loc;
    logic [11:0] o_total_count;
    logic        o_queue_empty;
    logic [5:0]  o_window_max;

    sliding_three_bucket_priority_queue #(.RING_DEPTH_LOG2(DEPTH_LOG2)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_item_pri(i_item_pri), .i_item_loc(i_item_loc),
        .o_valid(o_valid), .o_status(o_status), .o_out_pri(o_out_pri),
        .o_out_loc(o_out_loc), .o_total_count(o_total_count),
        .o_queue_empty(o_queue_empty), .o_window_max(o_window_max)
    );

    // queue shadow state
    logic [37:0] bucket_mem [0:3*DEPTH-1];
    int          ring_hd [3];
    int          ring_cnt [3];
    int          role_ring [3];
    int          win_max;
    bit          pri_seen;
    bit          stuck_fault;

    t_word_res   pending_words [$];
    int          mismatches = 0;
    int          cycle_cnt = 0;
    int          idle_pct = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int held_total();
        return ring_cnt[0] + ring_cnt[1] + ring_cnt[2];
    endfunction

    function automatic bit slide_window();
        int t, m, b, nb, nm, nh, i;
        t = role_ring[stbpq_pkg::ROLE_TOP];
        m = role_ring[stbpq_pkg::ROLE_MID];
        b = role_ring[stbpq_pkg::ROLE_BOT];
        nb = ring_cnt[b];
        nm = ring_cnt[m];
        if (nb <= nm) begin
            if (nb != 0) begin
                if (nm + nb > DEPTH) return 1'b0;
                nh = (ring_hd[m] - nb) & MASK;
                for (i = 0; i < nb; i++)
                    bucket_mem[m*DEPTH + ((nh + i) & MASK)] =
                        bucket_mem[b*DEPTH + ((ring_hd[b] + i) & MASK)];
                ring_hd[m] = nh;
                ring_cnt[m] = nm + nb;
                ring_hd[b] = 0;
                ring_cnt[b] = 0;
            end
            role_ring[stbpq_pkg::ROLE_TOP] = b;
            role_ring[stbpq_pkg::ROLE_MID] = t;
            role_ring[stbpq_pkg::ROLE_BOT] = m;
        end else begin
            if (nm != 0) begin
                if (nm + nb > DEPTH) return 1'b0;
                for (i = 0; i < nm; i++)
                    bucket_mem[b*DEPTH + ((ring_hd[b] + nb + i) & MASK)] =
                        bucket_mem[m*DEPTH + ((ring_hd[m] + i) & MASK)];
                ring_cnt[b] = nm + nb;
                ring_hd[m] = 0;
                ring_cnt[m] = 0;
            end
            role_ring[stbpq_pkg::ROLE_TOP] = m;
            role_ring[stbpq_pkg::ROLE_MID] = t;
            role_ring[stbpq_pkg::ROLE_BOT] = b;
        end
        win_max = (win_max + 1) & 63;
        return 1'b1;
    endfunction

    function automatic t_word_res queue_step(logic func, logic [5:0] pri, logic [31:0] loc);
        t_word_res r;
        int role, ring;
        logic [37:0] e;
        r = '{stbpq_pkg::ST_OK, 6'd0, 32'd0, 12'd0, 1'b0, 6'd0};
        e = '0;
        if (stuck_fault) begin
            r.status = stbpq_pkg::ST_FAULT;
        end else if (func == stbpq_pkg::FUNC_PUSH) begin
            if (!pri_seen) begin
                win_max = int'(pri);
                pri_seen = 1'b1;
                role = stbpq_pkg::ROLE_TOP;
            end else if (int'(pri) + 2 <= win_max) begin
                role = stbpq_pkg::ROLE_BOT;
            end else if (int'(pri) + 1 == win_max) begin
                role = stbpq_pkg::ROLE_MID;
            end else begin
                role = stbpq_pkg::ROLE_TOP;
                while (win_max < int'(pri)) begin
                    if (!slide_window()) begin
                        stuck_fault = 1'b1;
                        break;
                    end
                end
            end
            if (stuck_fault) begin
                r.status = stbpq_pkg::ST_FAULT;
            end else begin
                ring = role_ring[role];
                if (ring_cnt[ring] >= DEPTH) begin
                    r.status = stbpq_pkg::ST_FULL;
                end else begin
                    bucket_mem[ring*DEPTH + ((ring_hd[ring] + ring_cnt[ring]) & MASK)] =
                        {pri, loc};
                    ring_cnt[ring]++;
                end
            end
        end else begin
            if (ring_cnt[role_ring[stbpq_pkg::ROLE_BOT]] != 0) begin
                ring = role_ring[stbpq_pkg::ROLE_BOT];
                e = bucket_mem[ring*DEPTH + ring_hd[ring]];
                ring_hd[ring] = (ring_hd[ring] + 1) & MASK;
                ring_cnt[ring]--;
            end else if (ring_cnt[role_ring[stbpq_pkg::ROLE_MID]] != 0) begin
                ring = role_ring[stbpq_pkg::ROLE_MID];
                e = bucket_mem[ring*DEPTH + ((ring_hd[ring] + ring_cnt[ring] - 1) & MASK)];
                ring_cnt[ring]--;
            end else if (ring_cnt[role_ring[stbpq_pkg::ROLE_TOP]] != 0) begin
                ring = role_ring[stbpq_pkg::ROLE_TOP];
                e = bucket_mem[ring*DEPTH + ring_hd[ring]];
                ring_hd[ring] = (ring_hd[ring] + 1) & MASK;
                ring_cnt[ring]--;
            end else begin
                r.status = stbpq_pkg::ST_EMPTY;
            end
            if (r.status == stbpq_pkg::ST_OK) begin
                r.pri = e[37:32];
                r.loc = e[31:0];
            end
        end
        r.total = 12'(held_total());
        r.empty = (held_total() == 0);
        r.wmax = 6'(win_max);
        return r;
    endfunction

    // drive one word and hold it until the block takes it
    task automatic issue_word(logic func, logic [5:0] pri, logic [31:0] loc,
                              bit typed, t_word_res typed_res);
        t_word_res r;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_func <= func;
        i_item_pri <= pri;
        i_item_loc <= loc;
        do @(posedge i_clk); while (busy);
        r = queue_step(func, pri, loc);
        pending_words.push_back(typed ? typed_res : r);
    endtask

    task automatic push_word(logic [5:0] pri, logic [31:0] loc);
        t_word_res none;
        none = '{stbpq_pkg::ST_OK, 6'd0, 32'd0, 12'd0, 1'b0, 6'd0};
        issue_word(stbpq_pkg::FUNC_PUSH, pri, loc, 1'b0, none);
    endtask

    task automatic pop_word();
        t_word_res none;
        none = '{stbpq_pkg::ST_OK, 6'd0, 32'd0, 12'd0, 1'b0, 6'd0};
        issue_word(stbpq_pkg::FUNC_POP, 6'd0, 32'd0, 1'b0, none);
    endtask

    task automatic random_words(int n);
        int k, r, p;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 55) begin
                r = $urandom_range(0, 99);
                if (r < 8 && win_max < 50)
                    p = win_max + $urandom_range(1, 2);
                else if (r < 20)
                    p = $urandom_range(0, win_max);
                else begin
                    p = win_max - $urandom_range(0, 2);
                    if (p < 0) p = 0;
                end
                push_word(6'(p), $urandom);
            end else begin
                pop_word();
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_word_res x;
        if (i_rst_n && o_valid) begin
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: status %0d pri %0d loc %h",
                             o_status, o_out_pri, o_out_loc);
            end else begin
                x = pending_words.pop_front();
                if (o_status !== x.status || o_out_pri !== x.pri || o_out_loc !== x.loc ||
                    o_total_count !== x.total || o_queue_empty !== x.empty ||
                    o_window_max !== x.wmax) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp st %0d pri %0d loc %h tot %0d emp %0d max %0d,",
                                  " got st %0d pri %0d loc %h tot %0d emp %0d max %0d"},
                                 x.status, x.pri, x.loc, x.total, x.empty, x.wmax,
                                 o_status, o_out_pri, o_out_loc, o_total_count,
                                 o_queue_empty, o_window_max);
                end
            end
        end
    end

    t_dir_row dir_rows [] = '{
        '{stbpq_pkg::FUNC_POP,  6'd0, 32'h0, 1'b1,
          '{stbpq_pkg::ST_EMPTY, 6'd0, 32'h0, 12'd0, 1'b1, 6'd0}},
        '{stbpq_pkg::FUNC_PUSH, 6'd0, 32'h0, 1'b1,
          '{stbpq_pkg::ST_OK, 6'd0, 32'h0, 12'd1, 1'b0, 6'd0}},
        '{stbpq_pkg::FUNC_PUSH, 6'd3, 32'hFFFFFFFF, 1'b0,
          '{stbpq_pkg::ST_OK, 6'd0, 32'h0, 12'd0, 1'b0, 6'd0}},
        '{stbpq_pkg::FUNC_PUSH, 6'd0, 32'h5, 1'b0,
          '{stbpq_pkg::ST_OK, 6'd0, 32'h0, 12'd0, 1'b0, 6'd0}},
        '{stbpq_pkg::FUNC_PUSH, 6'd2, 32'h6, 1'b0,
          '{stbpq_pkg::ST_OK, 6'd0, 32'h0, 12'd0, 1'b0, 6'd0}},
        '{stbpq_pkg::FUNC_PUSH, 6'd3, 32'h7, 1'b0,
          '{stbpq_pkg::ST_OK, 6'd0, 32'h0, 12'd0, 1'b0, 6'd0}},
        '{stbpq_pkg::FUNC_PUSH, 6'd1, 32'h8, 1'b0,
          '{stbpq_pkg::ST_OK, 6'd0, 32'h0, 12'd0, 1'b0, 6'd0}},
        '{stbpq_pkg::FUNC_PUSH, 6'd2, 32'hA5A5A5A5, 1'b0,
          '{stbpq_pkg::ST_OK, 6'd0, 32'h0, 12'd0, 1'b0, 6'd0}},
        '{stbpq_pkg::FUNC_PUSH, 6'd4, 32'h9, 1'b0,
          '{stbpq_pkg::ST_OK, 6'd0, 32'h0, 12'd0, 1'b0, 6'd0}},
        '{stbpq_pkg::FUNC_POP,  6'd0, 32'h0, 1'b0,
          '{stbpq_pkg::ST_OK, 6'd0, 32'h0, 12'd0, 1'b0, 6'd0}},
        '{stbpq_pkg::FUNC_POP,  6'd0, 32'h0, 1'b0,
          '{stbpq_pkg::ST_OK, 6'd0, 32'h0, 12'd0, 1'b0, 6'd0}},
        '{stbpq_pkg::FUNC_POP,  6'd0, 32'h0, 1'b0,
          '{stbpq_pkg::ST_OK, 6'd0, 32'h0, 12'd0, 1'b0, 6'd0}},
        '{stbpq_pkg::FUNC_PUSH, 6'd7, 32'h12345678, 1'b0,
          '{stbpq_pkg::ST_OK, 6'd0, 32'h0, 12'd0, 1'b0, 6'd0}},
        '{stbpq_pkg::FUNC_PUSH, 6'd6, 32'h5A5A5A5A, 1'b0,
          '{stbpq_pkg::ST_OK, 6'd0, 32'h0, 12'd0, 1'b0, 6'd0}},
        '{stbpq_pkg::FUNC_PUSH, 6'd2, 32'hB, 1'b0,
          '{stbpq_pkg::ST_OK, 6'd0, 32'h0, 12'd0, 1'b0, 6'd0}},
        '{stbpq_pkg::FUNC_POP,  6'd0, 32'h0, 1'b0,
          '{stbpq_pkg::ST_OK, 6'd0, 32'h0, 12'd0, 1'b0, 6'd0}},
        '{stbpq_pkg::FUNC_POP,  6'd0, 32'h0, 1'b0,
          '{stbpq_pkg::ST_OK, 6'd0, 32'h0, 12'd0, 1'b0, 6'd0}},
        '{stbpq_pkg::FUNC_POP,  6'd0, 32'h0, 1'b0,
          '{stbpq_pkg::ST_OK, 6'd0, 32'h0, 12'd0, 1'b0, 6'd0}},
        '{stbpq_pkg::FUNC_POP,  6'd0, 32'h0, 1'b0,
          '{stbpq_pkg::ST_OK, 6'd0, 32'h0, 12'd0, 1'b0, 6'd0}},
        '{stbpq_pkg::FUNC_POP,  6'd0, 32'h0, 1'b0,
          '{stbpq_pkg::ST_OK, 6'd0, 32'h0, 12'd0, 1'b0, 6'd0}},
        '{stbpq_pkg::FUNC_POP,  6'd0, 32'h0, 1'b0,
          '{stbpq_pkg::ST_OK, 6'd0, 32'h0, 12'd0, 1'b0, 6'd0}},
        '{stbpq_pkg::FUNC_POP,  6'd0, 32'h0, 1'b0,
          '{stbpq_pkg::ST_OK, 6'd0, 32'h0, 12'd0, 1'b0, 6'd0}},
        '{stbpq_pkg::FUNC_POP,  6'd0, 32'h0, 1'b0,
          '{stbpq_pkg::ST_OK, 6'd0, 32'h0, 12'd0, 1'b0, 6'd0}},
        '{stbpq_pkg::FUNC_POP,  6'd0, 32'h0, 1'b0,
          '{stbpq_pkg::ST_OK, 6'd0, 32'h0, 12'd0, 1'b0, 6'd0}}
    };

    initial begin
        int k, top_pri;
        for (k = 0; k < 3; k++) begin
            ring_hd[k] = 0;
            ring_cnt[k] = 0;
            role_ring[k] = k;
        end
        win_max = 0;
        pri_seen = 1'b0;
        stuck_fault = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < dir_rows.size(); k++)
            issue_word(dir_rows[k].func, dir_rows[k].pri, dir_rows[k].loc,
                       dir_rows[k].typed, dir_rows[k].res);

        idle_pct = 35;
        random_words(180);

        // let the queue settle before going on
        start <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        @(posedge i_clk);

        idle_pct = 60;
        random_words(170);
        idle_pct = 0;
        random_words(170);

        // drain, fill one bucket past full, then force a merge overflow
        while (held_total() != 0) pop_word();
        top_pri = win_max;
        for (k = 0; k < DEPTH + 1; k++) push_word(6'(top_pri), $urandom);
        push_word(6'(top_pri + 1), $urandom);
        push_word(6'(top_pri - 1), $urandom);
        push_word(6'(top_pri + 2), $urandom);
        push_word(6'd63, 32'hFFFFFFFF);
        pop_word();
        push_word(6'd0, 32'h0);

        start <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && pending_words.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
